@@ design/q2e_pkg.sv @@
// ----------------------------------------------------------------------------
// q2e_pkg
// shared types, widths and the cordic arctangent table for the
// quaternion to euler angle converter
// ----------------------------------------------------------------------------
package q2e_pkg;

  localparam int VecW = 36;
  localparam int AccW = 32;

  typedef logic signed [15:0] angle_t;
  typedef logic signed [VecW-1:0] vec_t;

  localparam logic signed [AccW-1:0] Deg90Acc = 32'sd589824000;

  // round(atan(2^-i) * 100 * 180/pi * 2^16)
  function automatic logic signed [AccW-1:0] atan_entry(input logic [4:0] idx);
    logic signed [AccW-1:0] v;
    case (idx)
      5'd0:  v = 32'sd294912000;
      5'd1:  v = 32'sd174096719;
      5'd2:  v = 32'sd91987925;
      5'd3:  v = 32'sd46694507;
      5'd4:  v = 32'sd23437865;
      5'd5:  v = 32'sd11730358;
      5'd6:  v = 32'sd5866610;
      5'd7:  v = 32'sd2933484;
      5'd8:  v = 32'sd1466764;
      5'd9:  v = 32'sd733385;
      5'd10: v = 32'sd366693;
      5'd11: v = 32'sd183346;
      5'd12: v = 32'sd91673;
      5'd13: v = 32'sd45837;
      5'd14: v = 32'sd22918;
      5'd15: v = 32'sd11459;
      5'd16: v = 32'sd5730;
      5'd17: v = 32'sd2865;
      5'd18: v = 32'sd1432;
      5'd19: v = 32'sd716;
      5'd20: v = 32'sd358;
      5'd21: v = 32'sd179;
      5'd22: v = 32'sd90;
      5'd23: v = 32'sd45;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ design/q2e_isqrt.sv @@
// ----------------------------------------------------------------------------
// q2e_isqrt
// bit-serial integer square root of a 61-bit value, one result bit per cycle
// ----------------------------------------------------------------------------
module q2e_isqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [60:0] value,
  output logic        done,
  output logic [30:0] root
);
  import q2e_pkg::*;

  logic        busy;
  logic [60:0] rem;
  logic [60:0] res;
  logic [60:0] bitv;
  logic [61:0] trial;

  assign trial = {1'b0, res} + {1'b0, bitv};
  assign root  = res[30:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && bitv == 61'd1) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= value;
      res  <= '0;
      bitv <= 61'd1 << 60;
    end else if (busy) begin
      if ({1'b0, rem} >= trial) begin
        rem <= rem - trial[60:0];
        res <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
      bitv <= bitv >> 2;
    end
  end

endmodule

@@ design/q2e_cordic.sv @@
// ----------------------------------------------------------------------------
// q2e_cordic
// iterative vectoring cordic, atan2 in centidegrees, one rotation per cycle
// ----------------------------------------------------------------------------
module q2e_cordic #(
  parameter int STEPS = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  q2e_pkg::vec_t   y_in,
  input  q2e_pkg::vec_t   x_in,
  output logic            done,
  output q2e_pkg::angle_t angle
);
  import q2e_pkg::*;

  localparam int CW = $clog2(STEPS + 1);

  logic                   busy;
  logic [CW-1:0]          cnt;
  logic                   zero;
  vec_t                   x;
  vec_t                   y;
  logic signed [AccW-1:0] acc;
  vec_t                   dx;
  vec_t                   dy;
  logic signed [AccW:0]   rsum;
  logic signed [16:0]     rnd;
  angle_t                 clamped;

  assign dx = y >>> cnt;
  assign dy = x >>> cnt;
  assign rsum = {acc[AccW-1], acc} + 33'sd32768;
  assign rnd  = rsum[AccW:16];

  always_comb begin
    if (rnd > 17'sd18000) begin
      clamped = 16'sd18000;
    end else if (rnd < -17'sd18000) begin
      clamped = -16'sd18000;
    end else begin
      clamped = rnd[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CW'(STEPS)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      zero <= (x_in == '0) && (y_in == '0);
      cnt  <= '0;
      if (x_in < 0) begin
        if (y_in >= 0) begin
          x   <= y_in;
          y   <= -x_in;
          acc <= Deg90Acc;
        end else begin
          x   <= -y_in;
          y   <= x_in;
          acc <= -Deg90Acc;
        end
      end else begin
        x   <= x_in;
        y   <= y_in;
        acc <= '0;
      end
    end else if (busy) begin
      if (cnt == CW'(STEPS)) begin
        angle <= zero ? '0 : clamped;
      end else begin
        if (y >= 0) begin
          x   <= x + dx;
          y   <= y - dy;
          acc <= acc + atan_entry(5'(cnt));
        end else begin
          x   <= x - dx;
          y   <= y + dy;
          acc <= acc - atan_entry(5'(cnt));
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

endmodule

@@ design/quaternion_to_euler_relative_core.sv @@
// ----------------------------------------------------------------------------
// quaternion_to_euler_relative_core
// converts a q1.15 quaternion to zyx euler angles in centidegrees, with
// roll and pitch taken relative to the first sample after reset
// ----------------------------------------------------------------------------
// A sample runs from its input transfer through the products, the square, the square
// root and three cordic runs to a result, and the core returns to idle before it takes
// the next one; when the pitch sine saturates, the square root and the pitch cordic
// run are skipped. The core has one shared 32x32 multiplier (nine products and one
// square), a bit-serial square root of 31 steps, and one iterative cordic that runs
// roll, pitch and yaw one after another. A new sample is taken only when the core is
// idle; a finished result waits in the output register.
module quaternion_to_euler_relative_core #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               quat_valid,
  output logic               quat_ready,
  input  logic signed [15:0] quat_w,
  input  logic signed [15:0] quat_x,
  input  logic signed [15:0] quat_y,
  input  logic signed [15:0] quat_z,
  output logic               euler_valid,
  input  logic               euler_ready,
  output logic signed [16:0] roll_out,
  output logic signed [15:0] pitch_out,
  output logic signed [15:0] yaw_out,
  output logic               captured_reference
);
  import q2e_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE      = 8'b0000_0001,
    S_PROD      = 8'b0000_0010,
    S_SQ        = 8'b0000_0100,
    S_ROOT_GO   = 8'b0000_1000,
    S_ROOT_WAIT = 8'b0001_0000,
    S_ATAN_GO   = 8'b0010_0000,
    S_ATAN_WAIT = 8'b0100_0000,
    S_DONE      = 8'b1000_0000
  } state_t;

  typedef enum logic [1:0] {
    OP_ROLL  = 2'd0,
    OP_PITCH = 2'd1,
    OP_YAW   = 2'd2
  } op_t;

  state_t state;
  op_t    op;
  logic [3:0] pc;

  logic signed [15:0] qw, qx, qy, qz;
  logic signed [32:0] hsr, hcr, hsp, hsy, hcy;
  logic signed [63:0] p_reg;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;
  logic signed [32:0] p33;
  logic signed [31:0] sp32;
  logic               clamp_hi, clamp_lo, clamped;
  logic [30:0]        cval;
  angle_t             roll, pitch, yaw;

  logic signed [15:0] ref_roll, ref_pitch;
  logic               ref_valid;

  logic        root_start, root_done;
  logic [30:0] root;
  logic        cor_start, cor_done;
  vec_t        cor_y, cor_x;
  angle_t      cor_angle;
  logic        load_out;

  assign quat_ready = (state == S_IDLE);
  assign p33  = p_reg[32:0];
  assign sp32 = {hsp[30:0], 1'b0};
  assign clamp_hi = hsp >= 33'sd536870912;
  assign clamp_lo = hsp <= -33'sd536870912;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state == S_SQ) begin
      mul_a = sp32;
      mul_b = sp32;
    end else begin
      case (pc)
        4'd0: begin mul_a = 32'(qw); mul_b = 32'(qx); end
        4'd1: begin mul_a = 32'(qy); mul_b = 32'(qz); end
        4'd2: begin mul_a = 32'(qx); mul_b = 32'(qx); end
        4'd3: begin mul_a = 32'(qy); mul_b = 32'(qy); end
        4'd4: begin mul_a = 32'(qz); mul_b = 32'(qz); end
        4'd5: begin mul_a = 32'(qw); mul_b = 32'(qy); end
        4'd6: begin mul_a = 32'(qz); mul_b = 32'(qx); end
        4'd7: begin mul_a = 32'(qw); mul_b = 32'(qz); end
        4'd8: begin mul_a = 32'(qx); mul_b = 32'(qy); end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end
  end

  assign prod = mul_a * mul_b;

  assign root_start = (state == S_ROOT_GO);
  assign cor_start  = (state == S_ATAN_GO) && !(op == OP_PITCH && clamped);
  assign load_out   = (state == S_DONE) && (!euler_valid || euler_ready);

  always_comb begin
    case (op)
      OP_ROLL: begin
        cor_y = {{2{hsr[32]}}, hsr, 1'b0};
        cor_x = {{2{hcr[32]}}, hcr, 1'b0};
      end
      OP_PITCH: begin
        cor_y = {{2{hsp[32]}}, hsp, 1'b0};
        cor_x = {5'b0, cval};
      end
      OP_YAW: begin
        cor_y = {{2{hsy[32]}}, hsy, 1'b0};
        cor_x = {{2{hcy[32]}}, hcy, 1'b0};
      end
      default: begin
        cor_y = '0;
        cor_x = '0;
      end
    endcase
  end

  q2e_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (root_start),
    .value ((61'd1 << 60) - p_reg[60:0]),
    .done  (root_done),
    .root  (root)
  );

  q2e_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cor_start),
    .y_in  (cor_y),
    .x_in  (cor_x),
    .done  (cor_done),
    .angle (cor_angle)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      op          <= OP_ROLL;
      pc          <= '0;
      ref_valid   <= 1'b0;
      ref_roll    <= '0;
      ref_pitch   <= '0;
      euler_valid <= 1'b0;
    end else begin
      if (load_out) begin
        euler_valid <= 1'b1;
      end else if (euler_ready) begin
        euler_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (quat_valid) begin
            pc    <= '0;
            op    <= OP_ROLL;
            state <= S_PROD;
          end
        end
        S_PROD: begin
          pc <= pc + 1'b1;
          if (pc == 4'd9) begin
            state <= S_SQ;
          end
        end
        S_SQ: begin
          state <= (clamp_hi || clamp_lo) ? S_ATAN_GO : S_ROOT_GO;
        end
        S_ROOT_GO: begin
          state <= S_ROOT_WAIT;
        end
        S_ROOT_WAIT: begin
          if (root_done) begin
            state <= S_ATAN_GO;
          end
        end
        S_ATAN_GO: begin
          if (op == OP_PITCH && clamped) begin
            op <= OP_YAW;
          end else begin
            state <= S_ATAN_WAIT;
          end
        end
        S_ATAN_WAIT: begin
          if (cor_done) begin
            if (op == OP_YAW) begin
              state <= S_DONE;
            end else begin
              op    <= (op == OP_ROLL) ? OP_PITCH : OP_YAW;
              state <= S_ATAN_GO;
            end
          end
        end
        S_DONE: begin
          if (load_out) begin
            if (!ref_valid) begin
              ref_valid <= 1'b1;
              ref_roll  <= roll;
              ref_pitch <= pitch;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (state == S_IDLE && quat_valid) begin
      qw  <= quat_w;
      qx  <= quat_x;
      qy  <= quat_y;
      qz  <= quat_z;
      hsr <= '0;
      hcr <= 33'sd536870912;
      hsp <= '0;
      hsy <= '0;
      hcy <= 33'sd536870912;
    end
    if (state == S_PROD || state == S_SQ) begin
      p_reg <= prod;
    end
    if (state == S_PROD && pc != 4'd0) begin
      case (pc)
        4'd1: hsr <= hsr + p33;
        4'd2: hsr <= hsr + p33;
        4'd3: hcr <= hcr - p33;
        4'd4: begin
          hcr <= hcr - p33;
          hcy <= hcy - p33;
        end
        4'd5: hcy <= hcy - p33;
        4'd6: hsp <= hsp + p33;
        4'd7: hsp <= hsp - p33;
        4'd8: hsy <= hsy + p33;
        4'd9: hsy <= hsy + p33;
        default: hsr <= hsr;
      endcase
    end
    if (state == S_SQ) begin
      clamped <= clamp_hi || clamp_lo;
      if (clamp_hi) begin
        pitch <= 16'sd9000;
      end else if (clamp_lo) begin
        pitch <= -16'sd9000;
      end
    end
    if (state == S_ROOT_WAIT && root_done) begin
      cval <= root;
    end
    if (state == S_ATAN_WAIT && cor_done) begin
      case (op)
        OP_ROLL:  roll  <= cor_angle;
        OP_PITCH: pitch <= cor_angle;
        OP_YAW:   yaw   <= cor_angle;
        default:  yaw   <= yaw;
      endcase
    end
    if (load_out) begin
      yaw_out            <= yaw;
      captured_reference <= !ref_valid;
      if (!ref_valid) begin
        roll_out  <= 17'(roll);
        pitch_out <= pitch;
      end else begin
        roll_out  <= 17'(roll) - 17'(ref_roll);
        pitch_out <= pitch - ref_pitch;
      end
    end
  end

endmodule

@@ verif/quaternion_to_euler_relative_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_to_euler_relative_core_tb
// drives q1.15 quaternions into the converter and checks every roll, pitch
// and yaw result against a cordic predictor that tracks the captured
// reference, under random bursts, gaps and output stalls
// ----------------------------------------------------------------------------
module quaternion_to_euler_relative_core_tb;
  import q2e_pkg::*;

  localparam int CordicSteps = 16;
  localparam int NumRandom = 1080;

  typedef struct packed {
    logic signed [15:0] w;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } quat_t;

  typedef struct packed {
    logic signed [16:0] roll;
    logic signed [15:0] pitch;
    logic signed [15:0] yaw;
    logic               cap;
  } euler_t;

  typedef struct {
    quat_t  q;
    bit     known;
    euler_t e;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic quat_valid = 1'b0;
  logic quat_ready;
  logic signed [15:0] quat_w = '0, quat_x = '0, quat_y = '0, quat_z = '0;
  logic euler_valid;
  logic euler_ready = 1'b0;
  logic signed [16:0] roll_out;
  logic signed [15:0] pitch_out, yaw_out;
  logic captured_reference;

  always #10 clk = ~clk;

  quaternion_to_euler_relative_core #(.CORDIC_STEPS(CordicSteps)) u_top (
    .clk(clk), .rst(rst),
    .quat_valid(quat_valid), .quat_ready(quat_ready),
    .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
    .euler_valid(euler_valid), .euler_ready(euler_ready),
    .roll_out(roll_out), .pitch_out(pitch_out), .yaw_out(yaw_out),
    .captured_reference(captured_reference)
  );

  // predictor state
  logic signed [15:0] ref_roll_q, ref_pitch_q;
  bit ref_valid_q;
  euler_t angles_pending[$];
  int errors = 0;
  int n_sent = 0;
  int n_got = 0;
  int n_sat = 0;
  bit stim_done = 1'b0;
  bit hold_off = 1'b0;

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic int cordic_atan2(longint sy, longint cx);
    longint acc, t, dx, dy;
    int r;
    acc = 0;
    if (sy == 0 && cx == 0) return 0;
    if (cx < 0) begin
      t = cx;
      if (sy >= 0) begin
        cx = sy; sy = -t; acc = Deg90Acc;
      end else begin
        cx = -sy; sy = t; acc = -longint'(Deg90Acc);
      end
    end
    for (int i = 0; i < CordicSteps && i < 24; i++) begin
      dx = floor_shr(sy, i);
      dy = floor_shr(cx, i);
      if (sy >= 0) begin
        cx += dx; sy -= dy; acc += atan_entry(i[4:0]);
      end else begin
        cx -= dx; sy += dy; acc -= atan_entry(i[4:0]);
      end
    end
    r = int'(floor_shr(acc + 32768, 16));
    if (r > 18000) r = 18000;
    if (r < -18000) r = -18000;
    return r;
  endfunction

  function automatic longint root_floor(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b; res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic euler_t predict_angles(quat_t q);
    longint w, x, y, z, sr, cr, sp, sy, cy;
    longint one;
    int roll, pitch, yaw;
    euler_t e;
    one = 64'sd1 << 30;
    w = q.w; x = q.x; y = q.y; z = q.z;
    sr = 2 * (w * x + y * z);
    cr = one - 2 * (x * x + y * y);
    sp = 2 * (w * y - z * x);
    sy = 2 * (w * z + x * y);
    cy = one - 2 * (y * y + z * z);
    roll = cordic_atan2(sr, cr);
    yaw = cordic_atan2(sy, cy);
    if (sp >= one) pitch = 9000;
    else if (sp <= -one) pitch = -9000;
    else pitch = cordic_atan2(sp, root_floor((64'd1 << 60) - longint'(sp * sp)));
    if (!ref_valid_q) begin
      ref_roll_q = roll[15:0];
      ref_pitch_q = pitch[15:0];
      ref_valid_q = 1'b1;
      e.cap = 1'b1;
      e.roll = roll[16:0];
      e.pitch = pitch[15:0];
    end else begin
      e.cap = 1'b0;
      e.roll = 17'(roll - int'(ref_roll_q));
      e.pitch = 16'(pitch - int'(ref_pitch_q));
    end
    e.yaw = yaw[15:0];
    return e;
  endfunction

  function automatic quat_t rand_quat();
    quat_t q;
    longint a, b, c, d;
    if ($urandom_range(0, 9) < 7) begin
      // roughly unit quaternion
      a = longint'($urandom_range(0, 65535)) - 32768;
      b = longint'($urandom_range(0, 65535)) - 32768;
      c = longint'($urandom_range(0, 65535)) - 32768;
      d = longint'($urandom_range(0, 65535)) - 32768;
      while (a * a + b * b + c * c + d * d > (longint'(1) << 30)) begin
        a /= 2; b /= 2; c /= 2; d /= 2;
      end
      q = '{w: 16'(a), x: 16'(b), y: 16'(c), z: 16'(d)};
      if ($urandom_range(0, 3) == 0) q.w = 16'sh7fff;
    end else begin
      q = quat_t'({$urandom, $urandom});
    end
    return q;
  endfunction

  task automatic send_quat(quat_t q);
    quat_w <= q.w; quat_x <= q.x; quat_y <= q.y; quat_z <= q.z;
    quat_valid <= 1'b1;
    do @(posedge clk); while (!quat_ready);
    angles_pending.insert(angles_pending.size(), predict_angles(q));
    n_sent++;
    @(negedge clk);
  endtask

  dir_row_t dir_rows [16] = '{
    '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1, '{17'sd0, 16'sd0, 16'sd0, 1'b1}},
    '{'{16'sh7fff, 16'sd0, 16'sd0, 16'sd0}, 1, '{17'sd0, 16'sd0, 16'sd0, 1'b0}},
    '{'{16'sh7fff, 16'sd0, 16'sh7fff, 16'sd0}, 1,
      '{17'sd18000, 16'sd9000, 16'sd18000, 1'b0}},
    '{'{16'sh7fff, 16'sd0, -16'sh8000, 16'sd0}, 1,
      '{17'sd18000, -16'sd9000, 16'sd18000, 1'b0}},
    '{'{-16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000}, 0, '0},
    '{'{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff}, 0, '0},
    '{'{16'sd0, 16'sh7fff, 16'sd0, 16'sd0}, 0, '0},
    '{'{16'sd0, 16'sd0, 16'sh7fff, 16'sd0}, 0, '0},
    '{'{16'sd0, 16'sd0, 16'sd0, 16'sh7fff}, 0, '0},
    '{'{16'sd0, 16'sd0, 16'sd0, -16'sh8000}, 0, '0},
    '{'{16'sd23170, 16'sd23170, 16'sd0, 16'sd0}, 0, '0},
    '{'{16'sd23170, 16'sd0, 16'sd0, 16'sd23170}, 0, '0},
    '{'{16'sd23170, 16'sd0, 16'sd0, -16'sd23170}, 0, '0},
    '{'{16'sh7fff, 16'sh7fff, -16'sh8000, 16'sh7fff}, 0, '0},
    '{'{16'sd1, -16'sd1, 16'sd1, -16'sd1}, 0, '0},
    '{'{16'sh5555, -16'sh2aaa, 16'sh1234, -16'sh4321}, 0, '0}
  };

  // stimulus: table rows, then random bursts
  initial begin
    euler_t e;
    int burst;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (dir_rows[i]) begin
      send_quat(dir_rows[i].q);
      if (dir_rows[i].known) begin
        e = angles_pending.pop_back();
        if (e != dir_rows[i].e) begin
          $error("table row %0d: predictor gives %p, table %p", i, e, dir_rows[i].e);
          errors++;
        end
        angles_pending.insert(angles_pending.size(), dir_rows[i].e);
      end
    end
    for (int i = 0; i < NumRandom; ) begin
      burst = $urandom_range(1, 12);
      for (int k = 0; k < burst && i < NumRandom; k++, i++) send_quat(rand_quat());
      if ($urandom_range(0, 2) != 0) begin
        quat_valid <= 1'b0;
        repeat ($urandom_range(1, 150)) @(negedge clk);
      end
      if (i > 400 && i < 420) hold_off = 1'b1;
    end
    quat_valid <= 1'b0;
    stim_done = 1'b1;
  end

  // output back-pressure, with at least one long hold-off
  initial begin
    int mode;
    @(negedge clk);
    wait (!rst);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        hold_off = 1'b0;
        euler_ready <= 1'b0;
        repeat (2000) @(negedge clk);
      end
      mode = (n_got / 100) % 3;
      if (mode == 0) euler_ready <= 1'b1;
      else if (mode == 1) euler_ready <= ($urandom_range(0, 3) != 0);
      else euler_ready <= ($urandom_range(0, 7) == 0);
    end
  end

  // result check
  always @(posedge clk) begin
    euler_t exp_e;
    if (!rst && euler_valid && euler_ready) begin
      if (angles_pending.size() == 0) begin
        $error("transfer with no result pending");
        errors++;
      end else begin
        exp_e = angles_pending.pop_front();
        n_got++;
        if (exp_e.pitch == 9000 || exp_e.pitch == -9000) n_sat++;
        if (roll_out !== exp_e.roll) begin
          $error("roll_out: expected %0d, got %0d", exp_e.roll, roll_out); errors++;
        end
        if (pitch_out !== exp_e.pitch) begin
          $error("pitch_out: expected %0d, got %0d", exp_e.pitch, pitch_out); errors++;
        end
        if (yaw_out !== exp_e.yaw) begin
          $error("yaw_out: expected %0d, got %0d", exp_e.yaw, yaw_out); errors++;
        end
        if (captured_reference !== exp_e.cap) begin
          $error("captured_reference: expected %0d, got %0d", exp_e.cap,
                 captured_reference);
          errors++;
        end
      end
    end
  end

  initial begin
    wait (stim_done);
    while (angles_pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("sent %0d quaternions, checked %0d angle sets (%0d at +/-90 pitch)",
             n_sent, n_got, n_sat);
    if (errors == 0 && angles_pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule

@@ quaternion_to_euler_relative_core.f @@
design/q2e_pkg.sv
design/q2e_isqrt.sv
design/q2e_cordic.sv
design/quaternion_to_euler_relative_core.sv
verif/quaternion_to_euler_relative_core_tb.sv
